FILE: src/mgsa_pkg.sv
// Package for the max-gap seat allocator.
// Holds sizes, command and status codes, sequencer states and the gap-unit types.
// No dependencies.
package mgsa_pkg;

	localparam int MAX_SEATS = 64;
	localparam int SEAT_W    = $clog2(MAX_SEATS);
	localparam int CNT_W     = $clog2(MAX_SEATS + 1);

	localparam logic [CNT_W-1:0] SEAT_COUNT_RST = CNT_W'(MAX_SEATS);

	localparam logic CMD_PLACE   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	typedef enum logic [1:0] {
		GAP_FIRST,
		GAP_INNER,
		GAP_TAIL
	} gap_op_t;

	typedef struct packed {
		logic              take;
		logic [SEAT_W-1:0] gap_len;
		logic [SEAT_W-1:0] pos;
	} gap_res_t;

endpackage

FILE: src/max_gap_seat_allocator_top.sv
// Top level of the max-gap seat allocator: occupancy map, scan sequencer, result regs.
// Depends on mgsa_pkg and mgsa_gap_unit.
//
// channel   direction  handshake               payload
// request   in         start & !busy           cmd, seat_index
// result    out        done (one-cycle strobe) chosen_seat, status
// config    in         cfg_we                  cfg_wdata (seat_count)
//
// Place: one active seat per cycle (n = seat_count, saturated to 1..64) through the
// shared gap unit, then a finish state; result strobes on the cycle after that state.
// Release: result strobes on the cycle after the request; busy stays low.
// Reset clears the occupancy map at once and sets seat_count to 64.
// The receiver cannot stall; a new request may be taken in the strobe cycle.
module max_gap_seat_allocator_top
	import mgsa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              cmd,
	input  logic [SEAT_W-1:0] seat_index,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	output logic              done,
	output logic [SEAT_W-1:0] chosen_seat,
	output logic [1:0]        status
);

	state_t               state_q;
	logic [MAX_SEATS-1:0] map_q;
	logic [CNT_W-1:0]     seat_count_q;
	logic [SEAT_W-1:0]    i_q;
	logic [SEAT_W-1:0]    prev_q;
	logic [SEAT_W-1:0]    best_q;
	logic [SEAT_W-1:0]    res_q;
	logic                 have_prev_q;
	logic                 any_free_q;
	logic                 done_q;
	logic [SEAT_W-1:0]    seat_q;
	logic [1:0]           status_q;

	logic [CNT_W-1:0]  n_c;
	logic [CNT_W-1:0]  last_w;
	logic [SEAT_W-1:0] last_c;
	logic              accept;
	gap_op_t           gap_op;
	logic [SEAT_W-1:0] gap_cur;
	gap_res_t          gap_res;
	logic [SEAT_W-1:0] pick_c;

	always_comb begin
		priority if (seat_count_q == '0) begin
			n_c = CNT_W'(1);
		end else if (seat_count_q > CNT_W'(MAX_SEATS)) begin
			n_c = CNT_W'(MAX_SEATS);
		end else begin
			n_c = seat_count_q;
		end
	end

	assign last_w = n_c - CNT_W'(1);
	assign last_c = last_w[SEAT_W-1:0];
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		if (state_q == ST_FINISH) begin
			gap_op  = GAP_TAIL;
			gap_cur = last_c;
		end else begin
			gap_op  = have_prev_q ? GAP_INNER : GAP_FIRST;
			gap_cur = i_q;
		end
	end

	mgsa_gap_unit u_gap (
		.op   (gap_op),
		.cur  (gap_cur),
		.prev (prev_q),
		.best (best_q),
		.res  (gap_res)
	);

	// tail gap only counts once an occupant was seen
	assign pick_c = !have_prev_q ? '0 : (gap_res.take ? gap_res.pos : res_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seat_count_q <= SEAT_COUNT_RST;
		end else if (cfg_we) begin
			seat_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			map_q       <= '0;
			done_q      <= 1'b0;
			have_prev_q <= 1'b0;
			any_free_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd == CMD_RELEASE) begin
							seat_q <= seat_index;
							done_q <= 1'b1;
							if (map_q[seat_index]) begin
								map_q[seat_index] <= 1'b0;
								status_q          <= STATUS_OK;
							end else begin
								status_q <= STATUS_EMPTY;
							end
						end else begin
							i_q         <= '0;
							best_q      <= '0;
							res_q       <= '0;
							prev_q      <= '0;
							have_prev_q <= 1'b0;
							any_free_q  <= 1'b0;
							state_q     <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (map_q[i_q]) begin
						if (gap_res.take) begin
							best_q <= gap_res.gap_len;
							res_q  <= gap_res.pos;
						end
						prev_q      <= i_q;
						have_prev_q <= 1'b1;
					end else begin
						any_free_q <= 1'b1;
					end
					if (i_q == last_c) begin
						state_q <= ST_FINISH;
					end else begin
						i_q <= i_q + SEAT_W'(1);
					end
				end
				ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					if (any_free_q) begin
						seat_q        <= pick_c;
						status_q      <= STATUS_OK;
						map_q[pick_c] <= 1'b1;
					end else begin
						seat_q   <= '0;
						status_q <= STATUS_FULL;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign chosen_seat = seat_q;
	assign status      = status_q;

	a_full_seat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STATUS_FULL |-> chosen_seat == '0)
		else $error("full result with nonzero seat");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> i_q <= last_c)
		else $error("scan index past last active seat");

	a_place_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == CMD_PLACE |=> busy && !done)
		else $error("place request did not start a scan");

	a_empty_release_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STATUS_EMPTY |-> !map_q[chosen_seat])
		else $error("empty-release result on an occupied seat");

endmodule

FILE: src/mgsa_gap_unit.sv
// Shared gap evaluator: distance and seat for a leading, inner or trailing gap,
// and whether it beats the best distance so far.
// Depends on mgsa_pkg.
module mgsa_gap_unit
	import mgsa_pkg::*;
(
	input  gap_op_t           op,
	input  logic [SEAT_W-1:0] cur,
	input  logic [SEAT_W-1:0] prev,
	input  logic [SEAT_W-1:0] best,
	output gap_res_t          res
);

	logic [SEAT_W:0]   sum;
	logic [SEAT_W-1:0] diff;

	assign sum  = {1'b0, cur} + {1'b0, prev};
	assign diff = cur - prev;

	always_comb begin
		res = '0;
		unique case (op)
			GAP_FIRST: begin
				res.gap_len = cur;
				res.pos     = '0;
			end
			GAP_INNER: begin
				res.gap_len = {1'b0, diff[SEAT_W-1:1]};
				res.pos     = sum[SEAT_W:1];
			end
			GAP_TAIL: begin
				res.gap_len = diff;
				res.pos     = cur;
			end
			default: begin
				res.gap_len = '0;
				res.pos     = '0;
			end
		endcase
		res.take = (res.gap_len > best);
	end

endmodule
